// File: src/scd_pkg.sv
// Shared types and constants of the sector cache directory.
// No dependencies; used by the channel interfaces and the top level.
package scd_pkg;

	localparam int TICK_BITS     = 32;
	localparam int WAY_OUT_BITS  = 2;
	localparam int MASK_OUT_BITS = 4;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic [TICK_BITS-1:0]     tick_t;
	typedef logic [WAY_OUT_BITS-1:0]  way_out_t;
	typedef logic [MASK_OUT_BITS-1:0] mask_out_t;

endpackage

// File: src/scd_if.sv
// Valid/ready channels of the sector cache directory: access request and result.
// Depends on scd_pkg for the payload types.
interface scd_req_if #(
	parameter int SECTOR_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [SECTOR_BITS-1:0] sector;
	scd_pkg::tick_t         now_tick;

	modport source (output valid, opcode, sector, now_tick, input ready);
	modport sink   (input valid, opcode, sector, now_tick, output ready);
endinterface

interface scd_rsp_if;
	logic                valid;
	logic                ready;
	logic                hit;
	scd_pkg::way_out_t   way;
	logic                filled;
	scd_pkg::mask_out_t  invalidated_mask;

	modport source (output valid, hit, way, filled, invalidated_mask, input ready);
	modport sink   (input valid, hit, way, filled, invalidated_mask, output ready);
endinterface

// File: src/sector_cache_lru_directory.sv
// Tag and LRU directory of a fully associative sector cache, one way per cycle.
// A read scans the ways until it hits; a read miss scans every way, then fills a victim
// in ST_FILL; a write scans every way. The single way-scan sequencer (one tag compare
// and one stamp compare per cycle) takes no new access until ST_DONE hands off its result.
// A new access is taken while a result waits in the output register.
// Reset (arst_n low, asynchronous) clears all valid bits, tags and stamps.
module sector_cache_lru_directory #(
	parameter int WAYS         = 4,
	parameter int SECTOR_COUNT = 1024,
	parameter int STAMP_BITS   = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	scd_req_if.sink  req,
	scd_rsp_if.source rsp
);

	localparam int SECTOR_BITS = $clog2(SECTOR_COUNT);
	localparam int WAY_BITS    = $clog2(WAYS);
	localparam logic [WAY_BITS-1:0] LAST_WAY = WAY_BITS'(WAYS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [WAYS-1:0]        valid_q;
	logic [SECTOR_BITS-1:0] tag_q   [WAYS];
	logic [STAMP_BITS-1:0]  stamp_q [WAYS];

	logic [1:0]             state_q;
	logic [WAY_BITS-1:0]    idx_q;
	logic                   op_q;
	logic [SECTOR_BITS-1:0] sec_q;
	logic [STAMP_BITS-1:0]  now_q;
	logic                   inv_found_q;
	logic [WAY_BITS-1:0]    inv_way_q;
	logic [STAMP_BITS-1:0]  min_stamp_q;
	logic [WAY_BITS-1:0]    min_way_q;

	logic                   hit_q;
	logic [WAY_BITS-1:0]    way_q;
	logic                   filled_q;
	logic [WAYS-1:0]        mask_q;

	logic                   out_valid_q;
	logic                   out_hit_q;
	scd_pkg::way_out_t      out_way_q;
	logic                   out_filled_q;
	scd_pkg::mask_out_t     out_mask_q;

	logic                   rd_valid;
	logic                   tag_eq;
	logic                   stamp_lt;
	logic                   last;
	logic [WAY_BITS-1:0]    victim;
	logic                   out_free;
	logic [STAMP_BITS+scd_pkg::TICK_BITS-1:0] tick_ext;
	logic [WAY_BITS+scd_pkg::WAY_OUT_BITS-1:0] way_ext;
	logic [WAYS+scd_pkg::MASK_OUT_BITS-1:0]    mask_ext;

	assign rd_valid = valid_q[idx_q];
	assign tag_eq   = tag_q[idx_q] == sec_q;
	assign stamp_lt = stamp_q[idx_q] < min_stamp_q;
	assign last     = idx_q == LAST_WAY;
	assign victim   = inv_found_q ? inv_way_q : min_way_q;
	assign out_free = !out_valid_q || rsp.ready;
	assign tick_ext = {{STAMP_BITS{1'b0}}, req.now_tick};
	assign way_ext  = {{scd_pkg::WAY_OUT_BITS{1'b0}}, way_q};
	assign mask_ext = {{scd_pkg::MASK_OUT_BITS{1'b0}}, mask_q};

	assign req.ready            = state_q == ST_IDLE;
	assign rsp.valid            = out_valid_q;
	assign rsp.hit              = out_hit_q;
	assign rsp.way              = out_way_q;
	assign rsp.filled           = out_filled_q;
	assign rsp.invalidated_mask = out_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			for (int i = 0; i < WAYS; i++) begin
				tag_q[i]   <= '0;
				stamp_q[i] <= '0;
			end
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			inv_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q        <= req.opcode;
						sec_q       <= req.sector;
						now_q       <= tick_ext[STAMP_BITS-1:0];
						idx_q       <= '0;
						inv_found_q <= 1'b0;
						hit_q       <= 1'b0;
						filled_q    <= 1'b0;
						way_q       <= '0;
						mask_q      <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (op_q == scd_pkg::OP_READ) begin
						if (rd_valid && tag_eq) begin
							stamp_q[idx_q] <= now_q;
							hit_q          <= 1'b1;
							way_q          <= idx_q;
							state_q        <= ST_DONE;
						end else begin
							if (!rd_valid && !inv_found_q) begin
								inv_found_q <= 1'b1;
								inv_way_q   <= idx_q;
							end
							if (idx_q == '0 || stamp_lt) begin
								min_stamp_q <= stamp_q[idx_q];
								min_way_q   <= idx_q;
							end
							if (last) begin
								state_q <= ST_FILL;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end else begin
						if (tag_eq) begin
							valid_q[idx_q] <= 1'b0;
							mask_q[idx_q]  <= rd_valid;
						end
						if (last) begin
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FILL: begin
					valid_q[victim] <= 1'b1;
					tag_q[victim]   <= sec_q;
					stamp_q[victim] <= now_q;
					way_q           <= victim;
					filled_q        <= 1'b1;
					state_q         <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_hit_q    <= hit_q;
						out_way_q    <= way_ext[scd_pkg::WAY_OUT_BITS-1:0];
						out_filled_q <= filled_q;
						out_mask_q   <= mask_ext[scd_pkg::MASK_OUT_BITS-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_SCAN && idx_q == '0)
		else $error("accepted access did not start the way scan");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && !last && !(op_q == scd_pkg::OP_READ && rd_valid && tag_eq)
		|=> state_q == ST_SCAN && idx_q == $past(idx_q) + 1'b1)
		else $error("way scan skipped or stalled");

	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |=> valid_q[way_q] && filled_q && !hit_q)
		else $error("filled way not marked valid");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.hit || rsp.filled) |-> !(rsp.hit && rsp.filled)
		&& rsp.invalidated_mask == '0)
		else $error("result mixes read and write fields");

endmodule
